FILE: hw/rtl/dit_pkg.sv
// Package for the decimal integer tokenizer.
// Holds result kinds, the result record and the result queue sizing.
// No dependencies.
package dit_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int OUT_VALUE_BITS = 32;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);
    localparam int TDATA_BITS     = ((OUT_VALUE_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_INT      = 2'd0,
        KIND_BRACE    = 2'd1,
        KIND_SEMI     = 2'd2,
        KIND_EOI_ERR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                              kind;
        logic signed [OUT_VALUE_BITS-1:0]   value;
        logic                               last;
    } result_t;

    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

FILE: hw/rtl/dit_parse.sv
// Parser state and per-byte step logic of the decimal integer tokenizer.
// Turns one registered text beat into up to two results and the next state.
// Depends on dit_pkg.
module dit_parse
    import dit_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [7:0]  char_code,
    input  logic        end_of_input,
    output push_t       push
);

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic {
        PHASE_SKIP,
        PHASE_NUMBER
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NORMAL,
        ESC_BSLASH,
        ESC_BSLASH_NL,
        ESC_COMMENT
    } esc_t;

    typedef struct packed {
        esc_t        esc;
        logic        neg;
        logic        start;
        logic [3:0]  digit;
        logic        stop;
        kind_t       stop_kind;
    } scan_t;

    function automatic scan_t scan_idle(esc_t esc, logic neg);
        scan_t r;
        r.esc       = esc;
        r.neg       = neg;
        r.start     = 1'b0;
        r.digit     = 4'd0;
        r.stop      = 1'b0;
        r.stop_kind = KIND_BRACE;
        return r;
    endfunction

    function automatic scan_t deliver(logic [7:0] d, logic neg, esc_t esc);
        scan_t r;
        r           = scan_idle(esc, 1'b0);
        r.digit     = d[3:0];
        if (d >= CH_0 && d <= CH_9) begin
            r.start = 1'b1;
            r.neg   = neg;
        end else if (d == CH_MINUS) begin
            r.neg   = 1'b1;
        end else if (d == CH_RBRACE) begin
            r.stop  = 1'b1;
        end else if (d == CH_SEMI) begin
            r.stop      = 1'b1;
            r.stop_kind = KIND_SEMI;
        end
        return r;
    endfunction

    function automatic scan_t tail(logic [7:0] c, logic neg, esc_t esc);
        scan_t r;
        if (c == CH_HASH) begin
            r = scan_idle(ESC_COMMENT, neg);
        end else if (c == CH_NL || c == CH_TAB) begin
            r = deliver(CH_SPACE, neg, esc);
        end else begin
            r = deliver(c, neg, esc);
        end
        return r;
    endfunction

    function automatic scan_t scan_text(esc_t esc, logic neg, logic [7:0] c);
        scan_t r;
        unique case (esc)
            ESC_NORMAL: begin
                if (c == CH_BSLASH) r = scan_idle(ESC_BSLASH, neg);
                else                r = tail(c, neg, ESC_NORMAL);
            end
            ESC_BSLASH: begin
                if (c == CH_NL) r = scan_idle(ESC_BSLASH_NL, neg);
                else            r = tail(c, neg, ESC_NORMAL);
            end
            ESC_BSLASH_NL: begin
                r = tail(c, neg, ESC_NORMAL);
            end
            ESC_COMMENT: begin
                if (c == CH_NL) r = deliver(CH_SPACE, neg, ESC_NORMAL);
                else            r = scan_idle(ESC_COMMENT, neg);
            end
            default: begin
                r = scan_idle(ESC_NORMAL, neg);
            end
        endcase
        return r;
    endfunction

    phase_t                         phase_reg, phase_next;
    esc_t                           esc_reg, esc_next;
    logic                           neg_reg, neg_next;
    logic [VALUE_BITS-1:0]          acc_reg, acc_next;

    logic                           is_digit;
    logic [VALUE_BITS-1:0]          digit_ext;
    logic [VALUE_BITS-1:0]          mag;
    logic signed [VALUE_BITS-1:0]   sval;
    esc_t                           base_esc;
    logic                           base_neg;
    scan_t                          sc;
    logic                           first_v;
    logic                           second_v;
    result_t                        int_res;
    result_t                        second_res;

    always_comb begin
        is_digit  = (char_code >= CH_0) && (char_code <= CH_9);
        digit_ext = VALUE_BITS'(char_code[3:0]);
        mag       = neg_reg ? (~acc_reg + 1'b1) : acc_reg;
        sval      = signed'(mag);

        int_res.kind  = KIND_INT;
        int_res.value = OUT_VALUE_BITS'(sval);
        int_res.last  = 1'b0;

        base_esc = (phase_reg == PHASE_NUMBER) ? ESC_NORMAL : esc_reg;
        base_neg = (phase_reg == PHASE_NUMBER) ? 1'b0 : neg_reg;
        sc       = scan_text(base_esc, base_neg, char_code);

        phase_next = phase_reg;
        esc_next   = esc_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        first_v    = 1'b0;
        second_v   = 1'b0;

        second_res.kind  = end_of_input ? KIND_EOI_ERR : sc.stop_kind;
        second_res.value = '0;
        second_res.last  = 1'b1;

        if (fire) begin
            if (phase_reg == PHASE_NUMBER && !end_of_input && is_digit) begin
                acc_next = (acc_reg << 3) + (acc_reg << 1) + digit_ext;
            end else begin
                first_v = (phase_reg == PHASE_NUMBER);
                if (end_of_input) begin
                    second_v   = 1'b1;
                    phase_next = PHASE_SKIP;
                    esc_next   = ESC_NORMAL;
                    neg_next   = 1'b0;
                    acc_next   = '0;
                end else begin
                    second_v = sc.stop;
                    esc_next = sc.esc;
                    neg_next = sc.neg;
                    if (sc.start) begin
                        phase_next = PHASE_NUMBER;
                        acc_next   = VALUE_BITS'(sc.digit);
                    end else if (phase_reg == PHASE_NUMBER) begin
                        phase_next = PHASE_SKIP;
                        acc_next   = '0;
                    end
                end
            end
        end

        int_res.last = !second_v;
        push.v0 = first_v || second_v;
        push.v1 = first_v && second_v;
        push.r0 = first_v ? int_res : second_res;
        push.r1 = second_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_SKIP;
            esc_reg   <= ESC_NORMAL;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

    a_second_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> push.v0)
        else $error("second result without first");

    a_eoi_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && end_of_input) |=> (phase_reg == PHASE_SKIP && esc_reg == ESC_NORMAL
            && !neg_reg && acc_reg == '0))
        else $error("state not cleared after end of input");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> (!push.r0.last && push.r1.last))
        else $error("last marker misplaced on result pair");

    a_idle_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |-> !push.v0)
        else $error("result produced without an input beat");

endmodule

FILE: hw/rtl/dit_rfifo.sv
// Result queue of the decimal integer tokenizer.
// Takes up to two results per cycle and presents one per output beat.
// Depends on dit_pkg.
module dit_rfifo
    import dit_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  push_t    push,
    output logic     room,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_res
);

    result_t                    mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0]   count_reg, count_next;
    logic [FIFO_PTR_BITS-1:0]   wr_ptr_plus1;
    logic                       pop;

    always_comb begin
        pop          = out_valid && out_ready;
        wr_ptr_plus1 = wr_ptr_reg + 1'b1;
        wr_ptr_next  = wr_ptr_reg + FIFO_PTR_BITS'(push.v0) + FIFO_PTR_BITS'(push.v1);
        rd_ptr_next  = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        count_next   = count_reg + FIFO_CNT_BITS'(push.v0) + FIFO_CNT_BITS'(push.v1)
                       - FIFO_CNT_BITS'(pop);
    end

    assign room      = (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            mem_reg[wr_ptr_plus1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_with_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v0 |-> room)
        else $error("push into queue without room");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        FIFO_PTR_BITS'(wr_ptr_reg - rd_ptr_reg) == FIFO_PTR_BITS'(count_reg))
        else $error("queue pointers disagree with count");

endmodule

FILE: hw/rtl/decimal_integer_tokenizer.sv
// Decimal integer tokenizer: one text byte per input beat, signed integers out.
// Path from input beat to first result beat: input register, then result queue.
// Throughput: one input beat per cycle; a beat causing two results needs two
// output beats, and the 4-entry result queue holds input back when nearly full.
// Reset: synchronous, clears parser state, input register and result queue.
module decimal_integer_tokenizer
    import dit_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] char_code
    input  logic                    s_tlast,   // end_of_input
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_BITS-1:0]   m_tdata,   // [31:0] value
    output logic [1:0]              m_tuser,   // [1:0] kind
    output logic                    m_tlast
);

    logic           in_valid_reg;
    logic [7:0]     in_char_reg;
    logic           in_eoi_reg;
    logic           room;
    logic           fire;
    push_t          push;
    result_t        out_res;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
    end

    dit_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .char_code    (in_char_reg),
        .end_of_input (in_eoi_reg),
        .push         (push)
    );

    dit_rfifo u_rfifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = TDATA_BITS'(unsigned'(out_res.value));
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !room) |=> (in_valid_reg && $stable(in_char_reg)
            && $stable(in_eoi_reg)))
        else $error("input beat lost while queue full");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");

    a_int_value_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.kind != KIND_INT) |-> (out_res.value == '0))
        else $error("non-zero value on stop or error result");

endmodule

FILE: tb/decimal_integer_tokenizer_tb.sv
// Self-checking testbench for decimal_integer_tokenizer: random-gap text beats in,
// random-stall result beats out, each result checked against a cycle-free tokenizer model.
// Depends on dit_pkg (result kinds, tdata width) and the decimal_integer_tokenizer RTL.
`timescale 1ns / 1ps

module decimal_integer_tokenizer_tb;
    import dit_pkg::*;

    localparam int TEXT_BEATS   = 1750;
    localparam int HOLD_EVERY   = 400;
    localparam int MAX_REPORTS  = 100;

    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic { SKIPPING, IN_NUMBER } phase_t;
    typedef enum logic [1:0] { ESC_NONE, ESC_BSLASH, ESC_BSLASH_NL, ESC_COMMENT } esc_t;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        logic       hold;
    } text_beat_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    decimal_integer_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    text_beat_t text_beats[$];
    result_t    expected_tokens[$];
    result_t    step_tokens[$];
    text_beat_t cur_beat;

    phase_t      phase_q = SKIPPING;
    esc_t        esc_q   = ESC_NONE;
    logic        neg_q   = 1'b0;
    logic [31:0] acc_q   = '0;

    int  send_gap    = 0;
    int  recv_stall  = 0;
    bit  quiet_send  = 0;
    bit  quiet_recv  = 0;
    bit  hold_next   = 0;
    int  beats_sent  = 0;
    int  tokens_checked = 0;
    int  mismatches  = 0;
    int  kinds_seen[4];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("decimal_integer_tokenizer regression: fail");
        $finish;
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("ERROR t=%0t: %s", $time, msg);
    endtask

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic emit(input kind_t kind, input logic [31:0] value);
        result_t r;
        r.kind  = kind;
        r.value = value;
        r.last  = 1'b0;
        if (step_tokens.size() < 2)
            step_tokens.push_back(r);
    endtask

    task automatic deliver(input logic [7:0] c);
        if (is_digit(c)) begin
            acc_q   = {24'd0, c - CH_ZERO};
            phase_q = IN_NUMBER;
        end else if (c == CH_MINUS) begin
            neg_q = 1'b1;
        end else if (c == CH_RBRACE) begin
            emit(KIND_BRACE, '0);
            neg_q = 1'b0;
        end else if (c == CH_SEMI) begin
            emit(KIND_SEMI, '0);
            neg_q = 1'b0;
        end else begin
            neg_q = 1'b0;
        end
    endtask

    task automatic tail(input logic [7:0] c);
        if (c == CH_HASH)
            esc_q = ESC_COMMENT;
        else if (c == CH_NL || c == CH_TAB)
            deliver(CH_SPACE);
        else
            deliver(c);
    endtask

    task automatic scan_text(input logic [7:0] c);
        case (esc_q)
            ESC_NONE: begin
                if (c == CH_BSLASH) esc_q = ESC_BSLASH;
                else tail(c);
            end
            ESC_BSLASH: begin
                if (c == CH_NL) begin
                    esc_q = ESC_BSLASH_NL;
                end else begin
                    esc_q = ESC_NONE;
                    tail(c);
                end
            end
            ESC_BSLASH_NL: begin
                esc_q = ESC_NONE;
                tail(c);
            end
            default: begin
                if (c == CH_NL) begin
                    esc_q = ESC_NONE;
                    deliver(CH_SPACE);
                end
            end
        endcase
    endtask

    // Advance the model by one accepted beat and queue the results it causes.
    task automatic tokenize(input logic [7:0] c, input logic eoi);
        result_t r;
        step_tokens.delete();
        if (phase_q == IN_NUMBER) begin
            if (!eoi && is_digit(c)) begin
                acc_q = acc_q * 32'd10 + {24'd0, c - CH_ZERO};
            end else begin
                emit(KIND_INT, neg_q ? 32'd0 - acc_q : acc_q);
                neg_q   = 1'b0;
                acc_q   = '0;
                phase_q = SKIPPING;
                esc_q   = ESC_NONE;
                if (!eoi) scan_text(c);
            end
        end else if (!eoi) begin
            scan_text(c);
        end
        if (eoi) begin
            emit(KIND_EOI_ERR, '0);
            phase_q = SKIPPING;
            esc_q   = ESC_NONE;
            neg_q   = 1'b0;
            acc_q   = '0;
        end
        foreach (step_tokens[i]) begin
            r      = step_tokens[i];
            r.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(r);
        end
    endtask

    task automatic add_beat(input logic [7:0] c, input logic eoi = 1'b0);
        text_beat_t b;
        b.ch   = c;
        b.eoi  = eoi;
        b.hold = hold_next;
        hold_next = 0;
        text_beats.push_back(b);
    endtask

    task automatic add_eoi();
        add_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Fill the beat queue: directed corner cases, then random token streams.
    initial begin : stimulus
        int next_hold;
        int ndig;
        logic [7:0] b;

        add_beat(CH_MINUS);  add_beat("9");  add_beat(CH_RBRACE);
        add_beat(CH_SEMI);
        add_beat(CH_HASH);   add_beat("7");  add_beat(CH_NL);
        add_beat(CH_BSLASH); add_beat(CH_NL); add_beat(CH_BSLASH);
        add_beat(CH_TAB);    add_beat(8'hFF);
        add_beat("1");       add_beat("2");  add_eoi();
        add_beat(CH_BSLASH); add_eoi();
        add_beat(CH_HASH);   add_eoi();
        add_eoi();
        add_beat(CH_BSLASH); add_beat(CH_HASH); add_beat(CH_NL);
        add_beat("8");       add_beat(CH_BSLASH); add_beat("5");
        add_beat(CH_SEMI);

        hold_next = 1;
        next_hold = text_beats.size() + HOLD_EVERY;
        while (text_beats.size() < TEXT_BEATS) begin
            if (text_beats.size() >= next_hold) begin
                hold_next = 1;
                next_hold += HOLD_EVERY;
            end
            case ($urandom_range(0, 19))
                0, 1, 2: add_beat(8'($urandom_range(0, 255)));
                3: add_eoi();
                default: begin
                    if ($urandom_range(0, 1)) add_beat(CH_MINUS);
                    ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12)
                                                       : $urandom_range(1, 4);
                    repeat (ndig) add_beat(CH_ZERO + 8'($urandom_range(0, 9)));
                    case ($urandom_range(0, 11))
                        0:  add_beat(CH_SPACE);
                        1:  add_beat(CH_COMMA);
                        2:  add_beat(CH_NL);
                        3:  add_beat(CH_TAB);
                        4:  add_beat(CH_RBRACE);
                        5:  add_beat(CH_SEMI);
                        6: begin
                            add_beat(CH_HASH);
                            repeat ($urandom_range(0, 4)) begin
                                b = 8'($urandom_range(0, 255));
                                add_beat(b == CH_NL ? CH_SPACE : b);
                            end
                            add_beat(CH_NL);
                        end
                        7: begin
                            add_beat(CH_BSLASH);
                            add_beat(CH_NL);
                        end
                        8: begin
                            add_beat(CH_BSLASH);
                            add_beat(8'($urandom_range(0, 255)));
                        end
                        9:  add_beat(8'($urandom_range(128, 255)));
                        10: add_beat(CH_MINUS);
                        default: add_eoi();
                    endcase
                end
            endcase
        end
    end

    always @(posedge aclk) begin : driver
        logic vld;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            vld = s_tvalid;
            if (s_tvalid && s_tready) begin
                tokenize(cur_beat.ch, cur_beat.eoi);
                beats_sent++;
                vld      = 1'b0;
                send_gap = quiet_send ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 99) == 0) quiet_send = !quiet_send;
            end
            if (!vld && text_beats.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!text_beats[0].hold || expected_tokens.size() == 0) begin
                    cur_beat = text_beats.pop_front();
                    vld      = 1'b1;
                    s_tdata <= cur_beat.ch;
                    s_tlast <= cur_beat.eoi;
                end
            end
            s_tvalid <= vld;
        end
    end

    task automatic check_token();
        result_t     want;
        logic [1:0]  got_kind;
        logic [31:0] got_value;
        got_kind  = m_tuser;
        got_value = m_tdata[31:0];
        kinds_seen[got_kind]++;
        tokens_checked++;
        if (expected_tokens.size() == 0) begin
            report($sformatf("unexpected result kind %0d value %0d last %0b",
                             got_kind, $signed(got_value), m_tlast));
        end else begin
            want = expected_tokens.pop_front();
            if (got_kind != want.kind)
                report($sformatf("result %0d kind %0d, want %s",
                                 tokens_checked, got_kind, want.kind.name()));
            if (got_value != want.value)
                report($sformatf("result %0d value %0d, want %0d",
                                 tokens_checked, $signed(got_value), want.value));
            if (m_tlast != want.last)
                report($sformatf("result %0d last %0b, want %0b",
                                 tokens_checked, m_tlast, want.last));
        end
    endtask

    always @(posedge aclk) begin : monitor
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_token();
                recv_stall = quiet_recv ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 99) == 0) quiet_recv = !quiet_recv;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    initial begin : finish_run
        wait (aresetn === 1'b1);
        while (text_beats.size() > 0 || s_tvalid || expected_tokens.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (expected_tokens.size() > 0)
            report($sformatf("%0d results never arrived", expected_tokens.size()));
        $display("Sent %0d text beats, checked %0d results: %0d integers, %0d brace stops,",
                 beats_sent, tokens_checked, kinds_seen[KIND_INT], kinds_seen[KIND_BRACE]);
        $display("%0d semicolon stops, %0d end errors; %0d mismatches.",
                 kinds_seen[KIND_SEMI], kinds_seen[KIND_EOI_ERR], mismatches);
        if (mismatches == 0)
            $display("decimal_integer_tokenizer regression: pass");
        else
            $display("decimal_integer_tokenizer regression: fail");
        $finish;
    end

endmodule
